// ===== src/dtpn_pkg.sv =====
// Shared types, constants and month lookup for the date text parser.
`default_nettype none

package dtpn_pkg;

	localparam int unsigned CharW   = 8;
	localparam int unsigned AccW    = 14;
	localparam int unsigned MonthW  = 4;
	localparam int unsigned LenW    = 3;
	localparam int unsigned PackedW = 27;
	localparam int unsigned TdataW  = 32;
	localparam int unsigned NumMonths = 11;

	localparam logic [AccW-1:0]    AccMax      = AccW'(9999);
	localparam logic [CharW-1:0]   CharDash    = 8'h2D;
	localparam logic [CharW-1:0]   CharZero    = 8'h30;
	localparam logic [CharW-1:0]   CharNine    = 8'h39;
	localparam logic [LenW-1:0]    LenMonth    = LenW'(3);
	localparam logic [LenW-1:0]    LenMax      = LenW'(7);
	localparam logic [MonthW-1:0]  MonthOther  = MonthW'(12);

	// Three lower-case letters per month, first letter in the top byte.
	localparam logic [3*CharW-1:0] MonthNames [NumMonths] = '{
		24'h6A616E, 24'h666562, 24'h6D6172, 24'h617072,
		24'h6D6179, 24'h6A756E, 24'h6A756C, 24'h617567,
		24'h736570, 24'h6F6374, 24'h6E6F76
	};

	// Field currently being parsed.
	typedef enum logic [2:0] {
		PH_DAY   = 3'b001,
		PH_MONTH = 3'b010,
		PH_YEAR  = 3'b100
	} phase_t;

	// Final field values of one date string.
	typedef struct packed {
		logic [AccW-1:0]   day;
		logic [MonthW-1:0] month;
		logic [AccW-1:0]   year;
		logic              err;
	} date_fields_t;

	// Month number 1..11 for jan..nov, 12 for anything else.
	function automatic logic [MonthW-1:0] month_code(input logic [3*CharW-1:0] letters,
	                                                 input logic [LenW-1:0] len);
		logic [MonthW-1:0] code;
		code = MonthOther;
		if (len == LenMonth) begin
			for (int k = 0; k < NumMonths; k++) begin
				if (letters == MonthNames[k]) begin
					code = MonthW'(k + 1);
				end
			end
		end
		return code;
	endfunction

	// Decimal accumulate with saturation.
	function automatic logic [AccW-1:0] add_digit(input logic [AccW-1:0] acc,
	                                              input logic [CharW-1:0] c);
		logic [AccW+3:0] v;
		v = ({4'd0, acc} * (AccW+4)'(10)) + (AccW+4)'(c - CharZero);
		return (v > (AccW+4)'(AccMax)) ? AccMax : v[AccW-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/date_text_to_packed_number.sv =====
// Top level of the date text parser: input register, field tracking and packing stages.
`default_nettype none

// Parses a date string of the form day-month-year, one character per item on the
// slave stream, with tlast on the final character. Each string yields one result item
// carrying day + month*100 + year*10000 (month 1..11 for jan..nov, 12 otherwise), or
// zero with the error flag set when a number field held a non-digit or a dash was
// missing. One character is taken every cycle while the output side keeps up. After
// its final character is accepted, the input register takes the character, the field
// register then captures the fields, and the output register then loads the packing
// multiply-add; a stall on the output side can hold the last two steps.
module date_text_to_packed_number import dtpn_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [CharW-1:0]  s_tdata,   // [7:0] char_code
	input  wire logic              s_tlast,   // last_char
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [TdataW-1:0]      m_tdata,   // [26:0] packed_date, [31:27] zero
	output logic [0:0]             m_tuser    // [0] format_error
);

	logic               valid_s1;
	logic [CharW-1:0]   char_s1;
	logic               last_s1;
	logic               valid_s2;
	date_fields_t       fields_s2;
	date_fields_t       fields_new;
	logic [PackedW-1:0] packed_q;
	logic               err_q;
	logic               ready_s3;
	logic               ready_s2;
	logic               step_s1;
	logic               move_s2;
	logic [PackedW-1:0] packed_calc;

	// Handshake between stages; non-final characters need no room downstream.
	assign ready_s3 = !m_tvalid || m_tready;
	assign move_s2  = valid_s2 && ready_s3;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign step_s1  = valid_s1 && (!last_s1 || ready_s2);
	assign s_tready = !valid_s1 || step_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	dtpn_fields u_fields (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step_s1),
		.char_code (char_s1),
		.last_char (last_s1),
		.fields    (fields_new)
	);

	// Capture the finished fields of a string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= step_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && step_s1 && last_s1) begin
			fields_s2 <= fields_new;
		end
	end

	// Pack the fields into one number.
	always_comb begin
		packed_calc = PackedW'(fields_s2.day)
		            + PackedW'(fields_s2.month) * PackedW'(100)
		            + PackedW'(fields_s2.year) * PackedW'(10000);
		if (fields_s2.err) begin
			packed_calc = '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ready_s3) begin
			m_tvalid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			packed_q <= packed_calc;
			err_q    <= fields_s2.err;
		end
	end

	assign m_tdata = {(TdataW-PackedW)'(0), packed_q};
	assign m_tuser = err_q;

endmodule

`default_nettype wire

// ===== src/dtpn_fields.sv =====
// Per-character field tracking: day and year accumulators, month letters, error flag.
`default_nettype none

module dtpn_fields import dtpn_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  wire logic [CharW-1:0]   char_code,
	input  wire logic               last_char,
	output date_fields_t            fields
);

	phase_t              phase_q, phase_d;
	logic [AccW-1:0]     day_q, day_d;
	logic [AccW-1:0]     year_q, year_d;
	logic [3*CharW-1:0]  letters_q, letters_d;
	logic [LenW-1:0]     len_q, len_d;
	logic                err_q, err_d;
	logic                is_digit;
	logic                is_dash;

	assign is_digit = char_code inside {[CharZero:CharNine]};
	assign is_dash  = (char_code == CharDash);

	// Next state after this character.
	always_comb begin
		phase_d   = phase_q;
		day_d     = day_q;
		year_d    = year_q;
		letters_d = letters_q;
		len_d     = len_q;
		err_d     = err_q;
		case (phase_q)
			PH_DAY: begin
				if (is_dash) begin
					phase_d = PH_MONTH;
				end else if (is_digit) begin
					day_d = add_digit(day_q, char_code);
				end else begin
					err_d = 1'b1;
				end
			end
			PH_MONTH: begin
				if (is_dash) begin
					phase_d = PH_YEAR;
				end else begin
					if (len_q < LenMonth) begin
						letters_d = {letters_q[2*CharW-1:0], char_code};
					end
					if (len_q < LenMax) begin
						len_d = len_q + LenW'(1);
					end
				end
			end
			default: begin
				if (is_digit) begin
					year_d = add_digit(year_q, char_code);
				end else begin
					err_d = 1'b1;
				end
			end
		endcase
	end

	// Final field values, valid when this character ends the string.
	always_comb begin
		fields.day   = day_d;
		fields.month = month_code(letters_d, len_d);
		fields.year  = year_d;
		fields.err   = err_d || (phase_d == PH_DAY) || (phase_d == PH_MONTH);
	end

	// Parser state; the end of a string returns it to the day field.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_DAY;
			day_q     <= '0;
			year_q    <= '0;
			letters_q <= '0;
			len_q     <= '0;
			err_q     <= 1'b0;
		end else if (step) begin
			if (last_char) begin
				phase_q   <= PH_DAY;
				day_q     <= '0;
				year_q    <= '0;
				letters_q <= '0;
				len_q     <= '0;
				err_q     <= 1'b0;
			end else begin
				phase_q   <= phase_d;
				day_q     <= day_d;
				year_q    <= year_d;
				letters_q <= letters_d;
				len_q     <= len_d;
				err_q     <= err_d;
			end
		end
	end

endmodule

`default_nettype wire

// ===== bench/date_text_to_packed_number_checker.sv =====
// Checker for the date text parser: predicts each packed date and compares the output items.
`timescale 1ns / 1ps

module date_text_to_packed_number_checker import dtpn_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	input  wire logic [CharW-1:0]  s_tdata,   // [7:0] char_code
	input  wire logic              s_tlast,   // last_char
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [TdataW-1:0] m_tdata,   // [26:0] packed_date, [31:27] zero
	input  wire logic [0:0]        m_tuser,   // [0] format_error
	output int unsigned            fail_count,
	output int unsigned            dates_pending,
	output int unsigned            dates_checked,
	output int unsigned            dates_flagged
);

	localparam int unsigned ReportCap = 20;

	// Month spellings in order, first letter in the top byte.
	localparam logic [23:0] MonthText [11] = '{
		"jan", "feb", "mar", "apr", "may", "jun",
		"jul", "aug", "sep", "oct", "nov"
	};

	typedef struct packed {
		logic [PackedW-1:0] value;
		logic               bad;
	} packed_date_t;

	packed_date_t       dates_due [$];
	phase_t             field_now;
	logic [AccW-1:0]    day_sum;
	logic [AccW-1:0]    year_sum;
	logic [23:0]        mon_text;
	logic [LenW-1:0]    mon_len;
	logic               fault;
	int unsigned        fails;
	int unsigned        checked;
	int unsigned        flagged;

	// One more decimal digit, held at 9999 once it would go past.
	function automatic logic [AccW-1:0] next_decimal(input logic [AccW-1:0] sum,
	                                                 input logic [CharW-1:0] ch);
		int unsigned v;
		v = int'(sum) * 10 + int'(ch) - int'(CharZero);
		return (v > 9999) ? AccW'(9999) : AccW'(v);
	endfunction

	// Month number from the collected letters; 12 for anything unrecognized.
	function automatic int unsigned month_number(input logic [23:0] txt,
	                                             input logic [LenW-1:0] len);
		int unsigned num;
		num = 12;
		if (len == 3) begin
			for (int k = 0; k < 11; k++) begin
				if (txt == MonthText[k]) begin
					num = k + 1;
				end
			end
		end
		return num;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		packed_date_t want;
		logic         is_digit;
		logic [CharW-1:0] ch;
		int unsigned  total;
		if (!arst_n) begin
			dates_due.delete();
			field_now = PH_DAY;
			day_sum   = '0;
			year_sum  = '0;
			mon_text  = '0;
			mon_len   = '0;
			fault     = 1'b0;
			fails     = 0;
			checked   = 0;
			flagged   = 0;
		end else begin
			// Output side: compare against the oldest predicted date.
			if (m_tvalid && m_tready) begin
				if (dates_due.size() == 0) begin
					fails++;
					if (fails <= ReportCap)
						$display("%0t: unexpected result item, tdata=%h tuser=%b",
							$time, m_tdata, m_tuser);
				end else begin
					want = dates_due.pop_front();
					checked++;
					if (m_tdata[PackedW-1:0] !== want.value) begin
						fails++;
						if (fails <= ReportCap)
							$display("%0t: packed_date expected %0d, got %0d",
								$time, want.value, m_tdata[PackedW-1:0]);
					end
					if (m_tdata[TdataW-1:PackedW] !== '0) begin
						fails++;
						if (fails <= ReportCap)
							$display("%0t: tdata padding expected 0, got %h",
								$time, m_tdata[TdataW-1:PackedW]);
					end
					if (m_tuser[0] !== want.bad) begin
						fails++;
						if (fails <= ReportCap)
							$display("%0t: format_error expected %b, got %b",
								$time, want.bad, m_tuser[0]);
					end
				end
			end

			// Input side: advance the parser state by one character.
			if (s_tvalid && s_tready) begin
				ch = s_tdata;
				is_digit = (ch >= CharZero) && (ch <= CharNine);
				case (field_now)
					PH_DAY: begin
						if (ch == CharDash)
							field_now = PH_MONTH;
						else if (is_digit)
							day_sum = next_decimal(day_sum, ch);
						else
							fault = 1'b1;
					end
					PH_MONTH: begin
						if (ch == CharDash) begin
							field_now = PH_YEAR;
						end else begin
							if (mon_len < 3)
								mon_text = {mon_text[15:0], ch};
							if (mon_len < 7)
								mon_len = mon_len + 1'b1;
						end
					end
					default: begin
						if (is_digit)
							year_sum = next_decimal(year_sum, ch);
						else
							fault = 1'b1;
					end
				endcase

				// The final character closes the string and yields its result.
				if (s_tlast) begin
					want.bad = fault || (field_now != PH_YEAR);
					total = int'(day_sum) + month_number(mon_text, mon_len) * 100
						+ int'(year_sum) * 10000;
					want.value = want.bad ? '0 : PackedW'(total);
					if (want.bad)
						flagged++;
					dates_due.insert(dates_due.size(), want);
					field_now = PH_DAY;
					day_sum   = '0;
					year_sum  = '0;
					mon_text  = '0;
					mon_len   = '0;
					fault     = 1'b0;
				end
			end
		end
		fail_count    <= fails;
		dates_pending <= dates_due.size();
		dates_checked <= checked;
		dates_flagged <= flagged;
	end

endmodule

// ===== bench/date_text_to_packed_number_tb.sv =====
// Testbench top for the date text parser: character stimulus, output pacing and verdict.
`timescale 1ns / 1ps

module date_text_to_packed_number_tb;
	import dtpn_pkg::*;

	localparam int unsigned CharTarget  = 900;
	localparam int unsigned HoldAt      = 250;
	localparam int unsigned HoldCycles  = 300;
	localparam int unsigned QuietLimit  = 2000;

	typedef struct packed {
		logic [CharW-1:0] ch;
		logic             last;
	} text_char_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [CharW-1:0]  s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [TdataW-1:0] m_tdata;
	logic [0:0]        m_tuser;

	int unsigned fail_count;
	int unsigned dates_pending;
	int unsigned dates_checked;
	int unsigned dates_flagged;

	text_char_t  text_q [$];
	int unsigned chars_sent = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;
	int unsigned quiet_cycles = 0;
	logic        steady;

	string month_words [12] = '{
		"jan", "feb", "mar", "apr", "may", "jun",
		"jul", "aug", "sep", "oct", "nov", "dec"
	};

	date_text_to_packed_number dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	date_text_to_packed_number_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.fail_count    (fail_count),
		.dates_pending (dates_pending),
		.dates_checked (dates_checked),
		.dates_flagged (dates_flagged)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Idling is switched off for a stretch in the middle of the run.
	assign steady = (chars_sent >= 450) && (chars_sent < 650);

	// Queues a character sequence as one date string, tlast on its final byte.
	task automatic push_seq(input logic [CharW-1:0] seq [$]);
		text_char_t item;
		for (int i = 0; i < seq.size(); i++) begin
			item.ch   = seq[i];
			item.last = (i == seq.size() - 1);
			text_q.insert(text_q.size(), item);
		end
	endtask

	task automatic push_text(input string s);
		logic [CharW-1:0] seq [$];
		for (int i = 0; i < s.len(); i++)
			seq.insert(seq.size(), s[i]);
		push_seq(seq);
	endtask

	// Builds one random string: mostly well-formed dates, some damaged, some noise.
	task automatic push_random_date();
		logic [CharW-1:0] seq [$];
		int unsigned      kind;
		int unsigned      pick;
		int unsigned      n;
		int unsigned      pos;
		string            word;
		kind = $urandom_range(99);
		if (kind >= 85) begin
			n = $urandom_range(1, 8);
			repeat (n) seq.insert(seq.size(), CharW'($urandom_range(255)));
		end else begin
			// Day digits, usually few, now and then enough to saturate.
			n = ($urandom_range(9) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 4);
			repeat (n) seq.insert(seq.size(), CharZero + CharW'($urandom_range(9)));
			seq.insert(seq.size(), CharDash);

			// Month text: a real name most of the time, otherwise odd spellings.
			pick = $urandom_range(9);
			if (pick <= 6) begin
				word = month_words[$urandom_range(11)];
			end else if (pick == 7) begin
				word = month_words[$urandom_range(11)];
				word = word.toupper();
			end else begin
				word = "";
			end
			for (int i = 0; i < word.len(); i++)
				seq.insert(seq.size(), word[i]);
			if (pick == 8) begin
				repeat ($urandom_range(0, 5))
					seq.insert(seq.size(), 8'h61 + CharW'($urandom_range(25)));
			end else if (pick == 9) begin
				repeat ($urandom_range(1, 4))
					seq.insert(seq.size(), CharW'($urandom_range(255)));
			end
			seq.insert(seq.size(), CharDash);

			n = ($urandom_range(9) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 4);
			repeat (n) seq.insert(seq.size(), CharZero + CharW'($urandom_range(9)));

			// Damage: replace one byte, drop one byte, or cut the string short.
			if (kind >= 70) begin
				pos = $urandom_range(seq.size() - 1);
				case ($urandom_range(2))
					0: seq[pos] = CharW'($urandom_range(255));
					1: seq.delete(pos);
					default: while (seq.size() > pos + 1) void'(seq.pop_back());
				endcase
			end
		end
		if (seq.size() == 0)
			seq.insert(seq.size(), CharW'($urandom_range(255)));
		push_seq(seq);
	endtask

	// Character source: offers the next queued item, idling at random.
	always @(posedge clk or negedge arst_n) begin : feed
		text_char_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				chars_sent <= chars_sent + 1;
			if (!s_tvalid || s_tready) begin
				if (text_q.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
					nxt = text_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.ch;
					s_tlast  <= nxt.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result sink: random stalls plus one long hold-off while characters keep coming.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && chars_sent >= HoldAt) begin
			m_tready  <= 1'b0;
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 34);
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QuietLimit) begin
				$display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		// Directed strings: plain date, empty fields, error paths, byte extremes.
		push_text("12-nov-9");
		push_text("--");
		push_seq('{8'hFF});
		push_text("3-");
		push_text("-aug--");
		push_seq('{8'h39, CharDash, 8'h00, 8'hFF, 8'h6A, CharDash, 8'h30});
		push_text("7-jul-2024");
		while (text_q.size() < CharTarget)
			push_random_date();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every character taken, then every predicted date seen.
		do @(posedge clk); while (text_q.size() != 0 || s_tvalid);
		do @(posedge clk); while (dates_pending != 0);
		repeat (8) @(posedge clk);

		$display("Sent %0d characters; checked %0d date results, %0d of them flagged bad.",
			chars_sent, dates_checked, dates_flagged);
		$display("Included a %0d-cycle output hold-off and a stretch with no idling.",
			HoldCycles);
		if (fail_count == 0 && dates_pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
